FILE: rtl/ccc_pkg.sv
// Shared widths, codes and handshake types for the color filter cycle classifier.
package ccc_pkg;

  // Field widths
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned RATIO_W     = 26;
  localparam int unsigned RATIO_SHIFT = 10;
  localparam int unsigned CH_W        = 2;
  localparam int unsigned CLASS_W     = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = RATIO_W;

  // Threshold plus one, and the product of that with a clear count
  localparam int unsigned LIM_W  = RATIO_W + 1;
  localparam int unsigned PROD_W = LIM_W + COUNT_W;

  // Shift-add step counter: one step per multiplier bit
  localparam int unsigned STEP_W = $clog2(COUNT_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COUNT_W - 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_MIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_MIN  = 2'd3;

  // Filter channels
  localparam logic [CH_W-1:0] CH_CLEAR = 2'd0;
  localparam logic [CH_W-1:0] CH_RED   = 2'd1;
  localparam logic [CH_W-1:0] CH_GREEN = 2'd2;
  localparam logic [CH_W-1:0] CH_BLUE  = 2'd3;

  // Color class bits and the black class
  localparam logic [CLASS_W-1:0] CLASS_BLACK = 3'd0;
  localparam logic [CLASS_W-1:0] CLASS_RED   = 3'd1;
  localparam logic [CLASS_W-1:0] CLASS_BLUE  = 3'd2;
  localparam logic [CLASS_W-1:0] CLASS_GREEN = 3'd4;

  // Request to the multiply-compare unit
  typedef struct packed {
    logic                 start;
    logic [LIM_W-1:0]     lim_p1;   // threshold + 1
    logic [COUNT_W-1:0]   clear;    // clear count, nonzero
    logic [RATIO_W-1:0]   num;      // color count << 10
  } mc_cmd_t;

  // Answer from the multiply-compare unit
  typedef struct packed {
    logic done;    // one-cycle pulse
    logic above;   // num >= lim_p1 * clear
  } mc_stat_t;

endpackage

FILE: rtl/ccc_mulcmp.sv
// Shift-add multiplier with a final compare: decides floor(num/clear) > limit.
module ccc_mulcmp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ccc_pkg::mc_cmd_t  cmd_i,
  output ccc_pkg::mc_stat_t stat_o
);
  import ccc_pkg::*;

  typedef enum logic [1:0] {MC_IDLE, MC_MUL, MC_CMP} mc_state_e;

  mc_state_e            state_q, state_d;
  logic [PROD_W-1:0]    mcand_q, mcand_d;
  logic [COUNT_W-1:0]   mplier_q, mplier_d;
  logic [PROD_W-1:0]    acc_q, acc_d;
  logic [RATIO_W-1:0]   num_q, num_d;
  logic [STEP_W-1:0]    cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic                 above_q, above_d;
  logic [PROD_W-1:0]    acc_sum;

  // The one shared adder: accumulate the shifted multiplicand when the bit is set
  assign acc_sum = acc_q + (mplier_q[0] ? mcand_q : '0);

  always_comb begin
    state_d  = state_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    num_d    = num_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    above_d  = above_q;
    case (state_q)
      MC_IDLE: begin
        if (cmd_i.start) begin
          mcand_d  = {{COUNT_W{1'b0}}, cmd_i.lim_p1};
          mplier_d = cmd_i.clear;
          acc_d    = '0;
          num_d    = cmd_i.num;
          cnt_d    = '0;
          state_d  = MC_MUL;
        end
      end
      MC_MUL: begin
        acc_d    = acc_sum;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == STEP_LAST) begin
          state_d = MC_CMP;
        end
      end
      MC_CMP: begin
        // floor(num/clear) > limit  <=>  num >= (limit+1) * clear
        above_d = {{(PROD_W-RATIO_W){1'b0}}, num_q} >= acc_q;
        done_d  = 1'b1;
        state_d = MC_IDLE;
      end
      default: begin
        state_d = MC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= MC_IDLE;
      done_q   <= 1'b0;
      above_q  <= 1'b0;
      cnt_q    <= '0;
      mcand_q  <= '0;
      mplier_q <= '0;
      acc_q    <= '0;
      num_q    <= '0;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      above_q  <= above_d;
      cnt_q    <= cnt_d;
      mcand_q  <= mcand_d;
      mplier_q <= mplier_d;
      acc_q    <= acc_d;
      num_q    <= num_d;
    end
  end

  assign stat_o.done  = done_q;
  assign stat_o.above = above_q;

endmodule

FILE: rtl/color_filter_cycle_classifier_core.sv
// Top level: channel counting, filter select and ratio color classification.
//
// Each accepted item is a reading of a free-running 16-bit pulse counter. The
// difference from the previous reading is stored as the count of the filter
// channel now selected, the channel advances round-robin (clear, red, green,
// blue) and the select lines for the next channel come out with the result.
// The color class is found by one shared 16-step shift-add multiplier that
// tests count*1024 >= (threshold+1)*clear for red, green and blue in turn.
// An item goes from the check state through a start and a wait state per
// color to the done state, and its result is moved to the output register
// before the next item is taken. When the clear count is zero or below
// clear_min the class is black and the check state goes straight to done.
// Input stall is high while an item is in work; a finished result waits in
// the output register, so the next item can be taken while it is unread.
module color_filter_cycle_classifier_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration writes
  input  logic                            cfg_we_i,
  input  logic [ccc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ccc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Input items
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ccc_pkg::COUNT_W-1:0]     counter_reading_i,
  // Result items
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ccc_pkg::COUNT_W-1:0]     measured_count_o,
  output logic [ccc_pkg::CH_W-1:0]        closed_channel_o,
  output logic                            select_s2_o,
  output logic                            select_s3_o,
  output logic [ccc_pkg::CLASS_W-1:0]     color_class_o
);
  import ccc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_START, S_WAIT, S_DONE} state_e;

  // Configuration registers
  logic [COUNT_W-1:0] clear_min_q;
  logic [RATIO_W-1:0] red_min_q;
  logic [RATIO_W-1:0] green_min_q;
  logic [RATIO_W-1:0] blue_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_min_q <= '0;
      red_min_q   <= '0;
      green_min_q <= '0;
      blue_min_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CLEAR_MIN: clear_min_q <= cfg_data_i[COUNT_W-1:0];
        REG_RED_MIN:   red_min_q   <= cfg_data_i;
        REG_GREEN_MIN: green_min_q <= cfg_data_i;
        REG_BLUE_MIN:  blue_min_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state
  state_e             state_q, state_d;
  logic [COUNT_W-1:0] prev_q, prev_d;
  logic [CH_W-1:0]    chan_q, chan_d;
  logic [COUNT_W-1:0] counts_q [4];
  logic [COUNT_W-1:0] counts_d [4];
  logic [CH_W-1:0]    color_q, color_d;     // 0 red, 1 green, 2 blue
  logic [CLASS_W-1:0] cls_q, cls_d;
  // Working copy of this item's fields
  logic [COUNT_W-1:0] meas_q, meas_d;
  logic [CH_W-1:0]    closed_q, closed_d;
  // Output register
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] out_meas_q, out_meas_d;
  logic [CH_W-1:0]    out_closed_q, out_closed_d;
  logic               out_s2_q, out_s2_d;
  logic               out_s3_q, out_s3_d;
  logic [CLASS_W-1:0] out_cls_q, out_cls_d;

  mc_cmd_t            mc_cmd;
  mc_stat_t           mc_stat;
  logic [RATIO_W-1:0] lim_sel;
  logic [CLASS_W-1:0] cls_bit;
  logic [CH_W-1:0]    color_ch;
  logic [CH_W-1:0]    next_ch;
  logic               in_accept;
  logic               last_color;

  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign next_ch    = closed_q + 1'b1;
  assign last_color = (color_q == 2'd2);

  // Threshold, channel and class bit of the color under test
  always_comb begin
    case (color_q)
      2'd0: begin
        lim_sel  = red_min_q;
        color_ch = CH_RED;
        cls_bit  = CLASS_RED;
      end
      2'd1: begin
        lim_sel  = green_min_q;
        color_ch = CH_GREEN;
        cls_bit  = CLASS_GREEN;
      end
      default: begin
        lim_sel  = blue_min_q;
        color_ch = CH_BLUE;
        cls_bit  = CLASS_BLUE;
      end
    endcase
  end

  assign mc_cmd.start  = (state_q == S_START);
  assign mc_cmd.lim_p1 = {1'b0, lim_sel} + LIM_W'(1);
  assign mc_cmd.clear  = counts_q[CH_CLEAR];
  assign mc_cmd.num    = {counts_q[color_ch], {RATIO_SHIFT{1'b0}}};

  ccc_mulcmp u_mulcmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mc_cmd),
    .stat_o (mc_stat)
  );

  // Next-state logic
  always_comb begin
    state_d      = state_q;
    prev_d       = prev_q;
    chan_d       = chan_q;
    counts_d     = counts_q;
    color_d      = color_q;
    cls_d        = cls_q;
    meas_d       = meas_q;
    closed_d     = closed_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_meas_d   = out_meas_q;
    out_closed_d = out_closed_q;
    out_s2_d     = out_s2_q;
    out_s3_d     = out_s3_q;
    out_cls_d    = out_cls_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          meas_d           = counter_reading_i - prev_q;
          counts_d[chan_q] = counter_reading_i - prev_q;
          closed_d         = chan_q;
          prev_d           = counter_reading_i;
          chan_d           = chan_q + 1'b1;
          color_d          = '0;
          cls_d            = CLASS_BLACK;
          state_d          = S_CHECK;
        end
      end
      S_CHECK: begin
        // Zero or dim clear channel: black, no ratios
        if (counts_q[CH_CLEAR] == '0 || counts_q[CH_CLEAR] < clear_min_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_START;
        end
      end
      S_START: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (mc_stat.done) begin
          if (mc_stat.above) begin
            cls_d = cls_q | cls_bit;
          end
          if (last_color) begin
            state_d = S_DONE;
          end else begin
            color_d = color_q + 1'b1;
            state_d = S_START;
          end
        end
      end
      S_DONE: begin
        // Hand over once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_meas_d   = meas_q;
          out_closed_d = closed_q;
          out_s2_d     = !next_ch[0];
          out_s3_d     = next_ch[1];
          out_cls_d    = cls_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      prev_q       <= '0;
      chan_q       <= CH_CLEAR;
      counts_q     <= '{default: '0};
      color_q      <= '0;
      cls_q        <= CLASS_BLACK;
      meas_q       <= '0;
      closed_q     <= CH_CLEAR;
      out_valid_q  <= 1'b0;
      out_meas_q   <= '0;
      out_closed_q <= CH_CLEAR;
      out_s2_q     <= 1'b0;
      out_s3_q     <= 1'b0;
      out_cls_q    <= CLASS_BLACK;
    end else begin
      state_q      <= state_d;
      prev_q       <= prev_d;
      chan_q       <= chan_d;
      counts_q     <= counts_d;
      color_q      <= color_d;
      cls_q        <= cls_d;
      meas_q       <= meas_d;
      closed_q     <= closed_d;
      out_valid_q  <= out_valid_d;
      out_meas_q   <= out_meas_d;
      out_closed_q <= out_closed_d;
      out_s2_q     <= out_s2_d;
      out_s3_q     <= out_s3_d;
      out_cls_q    <= out_cls_d;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign measured_count_o = out_meas_q;
  assign closed_channel_o = out_closed_q;
  assign select_s2_o      = out_s2_q;
  assign select_s3_o      = out_s3_q;
  assign color_class_o    = out_cls_q;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the color filter cycle classifier core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ccc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned NUM_ROWS    = 25;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS = 190;
  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

  typedef struct packed {
    logic [COUNT_W-1:0] measured;
    logic [CH_W-1:0]    channel;
    logic               s2;
    logic               s3;
    logic [CLASS_W-1:0] cls;
  } filter_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [RATIO_W-1:0]   value;    // counter reading or register data
    logic                 typed;    // expected result given in the row
    filter_result_t       known;
  } stim_row_t;

  localparam filter_result_t NO_RESULT = '0;

  // DUT signals
  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [COUNT_W-1:0]    counter_reading_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [COUNT_W-1:0]    measured_count_o;
  logic [CH_W-1:0]       closed_channel_o;
  logic                  select_s2_o;
  logic                  select_s3_o;
  logic [CLASS_W-1:0]    color_class_o;

  color_filter_cycle_classifier_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .counter_reading_i (counter_reading_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .measured_count_o  (measured_count_o),
    .closed_channel_o  (closed_channel_o),
    .select_s2_o       (select_s2_o),
    .select_s3_o       (select_s3_o),
    .color_class_o     (color_class_o)
  );

  // Directed items: wrap-around, zero clear, clear of one, largest ratios,
  // wide clear_min data, and red/green thresholds right at a ratio of 1024
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h0000, 1'b1,
      '{16'h0000, CH_CLEAR, 1'b0, 1'b0, CLASS_BLACK}},
    '{ROW_ITEM, REG_CLEAR_MIN, 26'hFFFF, 1'b1,
      '{16'hFFFF, CH_RED, 1'b1, 1'b1, CLASS_BLACK}},
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h0000, 1'b1,
      '{16'h0001, CH_GREEN, 1'b0, 1'b1, CLASS_BLACK}},
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h0000, 1'b1,
      '{16'h0000, CH_BLUE, 1'b1, 1'b0, CLASS_BLACK}},
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h0400, 1'b1,
      '{16'h0400, CH_CLEAR, 1'b0, 1'b0, CLASS_RED | CLASS_GREEN}},
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h0800, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h0C00, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h0C00, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h0C01, 1'b0, NO_RESULT},   // clear of one
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h0C00, 1'b0, NO_RESULT},   // red 0xFFFF
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h0C00, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h0BFF, 1'b0, NO_RESULT},   // blue 0xFFFF
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h0BFF, 1'b0, NO_RESULT},   // clear zero
    '{ROW_CFG,  REG_CLEAR_MIN, 26'h3FF0010, 1'b0, NO_RESULT},
    '{ROW_CFG,  REG_RED_MIN,   26'd1023, 1'b0, NO_RESULT},
    '{ROW_CFG,  REG_GREEN_MIN, 26'd1024, 1'b0, NO_RESULT},
    '{ROW_CFG,  REG_BLUE_MIN,  26'h3FFFFFF, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h0FFF, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h13FF, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h13FE, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h140D, 1'b0, NO_RESULT},   // clear below min
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h180D, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h1C0D, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h1C0D, 1'b0, NO_RESULT},
    '{ROW_ITEM, REG_CLEAR_MIN, 26'h200D, 1'b0, NO_RESULT}    // ratio at 1024
  };

  // Predictor state and thresholds
  logic [COUNT_W-1:0] last_reading;
  logic [CH_W-1:0]    open_channel;
  logic [COUNT_W-1:0] ch_counts [4];
  logic [COUNT_W-1:0] clear_min_r;
  logic [RATIO_W-1:0] red_min_r;
  logic [RATIO_W-1:0] green_min_r;
  logic [RATIO_W-1:0] blue_min_r;

  filter_result_t pending_results [$];
  int unsigned    errors;
  int unsigned    cycles;
  bit             tx_idle_on;
  bit             rx_idle_on;
  int unsigned    stall_left;

  // floor(count*1024/clear) strictly above the threshold
  function automatic logic ratio_exceeds(logic [COUNT_W-1:0] count,
                                         logic [COUNT_W-1:0] clear,
                                         logic [RATIO_W-1:0] limit);
    logic [RATIO_W-1:0] ratio;
    ratio = {count, 10'd0} / {10'd0, clear};
    return ratio > limit;
  endfunction

  function automatic logic [CLASS_W-1:0] classify_counts();
    logic [COUNT_W-1:0] clear;
    logic [CLASS_W-1:0] cls;
    clear = ch_counts[CH_CLEAR];
    cls   = CLASS_BLACK;
    if (clear != '0 && clear >= clear_min_r) begin
      if (ratio_exceeds(ch_counts[CH_RED], clear, red_min_r))     cls |= CLASS_RED;
      if (ratio_exceeds(ch_counts[CH_GREEN], clear, green_min_r)) cls |= CLASS_GREEN;
      if (ratio_exceeds(ch_counts[CH_BLUE], clear, blue_min_r))   cls |= CLASS_BLUE;
    end
    return cls;
  endfunction

  // Close the open channel with this reading and advance round-robin
  function automatic filter_result_t advance_filter_cycle(logic [COUNT_W-1:0] reading);
    filter_result_t r;
    logic [CH_W-1:0] next_ch;
    r.measured              = reading - last_reading;
    r.channel               = open_channel;
    ch_counts[open_channel] = r.measured;
    last_reading            = reading;
    next_ch                 = open_channel + 1'b1;
    open_channel            = next_ch;
    r.s2                    = ~next_ch[0];
    r.s3                    = next_ch[1];
    r.cls                   = classify_counts();
    return r;
  endfunction

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Cycle limit
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("color_filter_cycle_classifier_core verification failed");
      $finish;
    end
  end

  // Receiver stall bursts while rx_idle_on is set
  initial begin
    out_stall_i = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        out_stall_i = 1'b1;
        stall_left  = $urandom_range(0, 6);
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    filter_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result item with nothing expected: measured_count %0h", measured_count_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (measured_count_o !== want.measured) begin
          $error("measured_count: expected %0h, got %0h", want.measured, measured_count_o);
          errors++;
        end
        if (closed_channel_o !== want.channel) begin
          $error("closed_channel: expected %0d, got %0d", want.channel, closed_channel_o);
          errors++;
        end
        if (select_s2_o !== want.s2) begin
          $error("select_s2: expected %0b, got %0b", want.s2, select_s2_o);
          errors++;
        end
        if (select_s3_o !== want.s3) begin
          $error("select_s3: expected %0b, got %0b", want.s3, select_s3_o);
          errors++;
        end
        if (color_class_o !== want.cls) begin
          $error("color_class: expected %0d, got %0d", want.cls, color_class_o);
          errors++;
        end
      end
    end
  end

  // Offer one reading, wait for acceptance, queue its result
  task automatic send_reading(input logic [COUNT_W-1:0] reading, input logic typed,
                              input filter_result_t known);
    filter_result_t r;
    counter_reading_i = reading;
    in_valid_i        = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    r = advance_filter_cycle(reading);
    pending_results.push_back(typed ? known : r);
    @(negedge clk_i);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One register write; the caller drops the write enable
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    case (idx)
      REG_CLEAR_MIN: clear_min_r = data[COUNT_W-1:0];
      REG_RED_MIN:   red_min_r   = data;
      REG_GREEN_MIN: green_min_r = data;
      REG_BLUE_MIN:  blue_min_r  = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  function automatic logic [RATIO_W-1:0] pick_threshold();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return RATIO_MAX;
      2:       return RATIO_W'($urandom_range(0, 4096));
      3:       return RATIO_W'(1024 - $urandom_range(0, 1));  // equal-count ratio edge
      default: return RATIO_W'($urandom);
    endcase
  endfunction

  // Main sequence
  initial begin
    logic [COUNT_W-1:0] delta;
    logic [COUNT_W-1:0] reading;
    logic [COUNT_W-1:0] phase_delta;
    logic [COUNT_W-1:0] clear_lim;
    int unsigned        delta_lo;
    int unsigned        delta_hi;

    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = REG_CLEAR_MIN;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    counter_reading_i = '0;
    tx_idle_on        = 1'b0;
    rx_idle_on        = 1'b0;
    errors            = 0;
    last_reading      = '0;
    open_channel      = CH_CLEAR;
    foreach (ch_counts[i]) ch_counts[i] = '0;
    clear_min_r       = '0;
    red_min_r         = '0;
    green_min_r       = '0;
    blue_min_r        = '0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
        cfg_we_i = 1'b0;
      end else begin
        send_reading(directed_rows[i].value[COUNT_W-1:0], directed_rows[i].typed,
                     directed_rows[i].known);
      end
    end

    // Random phases, each with its own thresholds, count scale and idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      case ($urandom_range(0, 2))
        0:       begin delta_lo = 1;   delta_hi = 64;    end
        1:       begin delta_lo = 256; delta_hi = 4096;  end
        default: begin delta_lo = 0;   delta_hi = 65535; end
      endcase
      phase_delta = COUNT_W'($urandom_range(1, 65535));
      case ($urandom_range(0, 3))
        0:       clear_lim = '0;
        1:       clear_lim = '1;
        default: clear_lim = COUNT_W'($urandom_range(0, delta_hi));
      endcase
      write_reg(REG_CLEAR_MIN, {10'($urandom), clear_lim});
      write_reg(REG_RED_MIN, pick_threshold());
      write_reg(REG_GREEN_MIN, pick_threshold());
      write_reg(REG_BLUE_MIN, pick_threshold());
      cfg_we_i = 1'b0;

      // one stretch without idling, and a quiet last phase
      if (p == 1 || p == NUM_PHASES - 1) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end else begin
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 19))
          0, 1:    delta = '0;
          2, 3:    delta = COUNT_W'($urandom) - last_reading;
          4:       delta = '1;
          5:       delta = 16'd1;
          6, 7, 8: delta = phase_delta;
          default: delta = COUNT_W'($urandom_range(delta_lo, delta_hi));
        endcase
        reading = last_reading + delta;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
          in_valid_i = 1'b0;
          repeat ($urandom_range(1, 7)) @(negedge clk_i);
        end
        send_reading(reading, 1'b0, NO_RESULT);
      end
    end

    drain_results();
    repeat (70) @(posedge clk_i);
    if (errors == 0) begin
      $display("color_filter_cycle_classifier_core verification clean");
    end else begin
      $display("color_filter_cycle_classifier_core verification failed");
    end
    $finish;
  end

endmodule
